>>> rtl/slp_pkg.sv
// Package for the spectral Leray projection block: transaction payload types,
// field widths, register indexes and divider sizing. It depends on nothing.
package slp_pkg;

	localparam int IDX_W      = 10;
	localparam int GRID_W     = 11;
	localparam int COMP_W     = 32;
	localparam int K_W        = 12;
	localparam int PROD_W     = 44;
	localparam int DOT_W      = 46;
	localparam int SQ_W       = 21;
	localparam int DEN_W      = 22;
	localparam int NUM_W      = 58;
	localparam int QUO_W      = 33;
	localparam int N_W        = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam int MAX_GRID_DEFAULT = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID = 1'd1;

	localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;

	typedef struct packed {
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic [IDX_W-1:0]         depth_index;
		logic signed [COMP_W-1:0] comp1_re;
		logic signed [COMP_W-1:0] comp1_im;
		logic signed [COMP_W-1:0] comp2_re;
		logic signed [COMP_W-1:0] comp2_im;
		logic signed [COMP_W-1:0] comp3_re;
		logic signed [COMP_W-1:0] comp3_im;
	} coef_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] proj1_re;
		logic signed [COMP_W-1:0] proj1_im;
		logic signed [COMP_W-1:0] proj2_re;
		logic signed [COMP_W-1:0] proj2_im;
		logic signed [COMP_W-1:0] proj3_re;
		logic signed [COMP_W-1:0] proj3_im;
	} proj_t;

endpackage

>>> rtl/slp_div.sv
// One projection lane: pipelined signed division of k*dot by |k|^2, one quotient
// bit per stage, then subtraction from the component and saturation. Uses slp_pkg.
module slp_div (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [slp_pkg::NUM_W-1:0]    num,
	input  logic [slp_pkg::DEN_W-1:0]           den,
	input  logic signed [slp_pkg::COMP_W-1:0]   comp,
	input  logic                                force_zero,
	output logic signed [slp_pkg::COMP_W-1:0]   res
);
	import slp_pkg::*;

	localparam logic signed [COMP_W+2:0] SAT_HI = (COMP_W+3)'(2147483647);
	localparam logic signed [COMP_W+2:0] SAT_LO = -(COMP_W+3)'(64'sd2147483648);

	logic [NUM_W-1:0] mag;
	logic             neg;

	logic [DEN_W-1:0]         rem_s  [QUO_W+1];
	logic [QUO_W-1:0]         ql_s   [QUO_W+1];
	logic [DEN_W-1:0]         den_s  [QUO_W+1];
	logic signed [COMP_W-1:0] comp_s [QUO_W+1];
	logic                     neg_s  [QUO_W+1];
	logic                     zero_s [QUO_W+1];

	logic signed [QUO_W:0]    quo;
	logic signed [COMP_W+2:0] diff;

	// The quotient magnitude is known to stay below 2^QUO_W, so the bits above
	// the quotient field start off as a remainder that is already below |k|^2.
	assign neg = num[NUM_W-1];
	assign mag = neg ? (~num + NUM_W'(1)) : num;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= mag[QUO_W +: DEN_W];
			ql_s[0]   <= mag[QUO_W-1:0];
			den_s[0]  <= den;
			comp_s[0] <= comp;
			neg_s[0]  <= neg;
			zero_s[0] <= force_zero;
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [DEN_W:0]   trial;
		logic [DEN_W+1:0] sub;
		logic             ge;

		assign trial = {rem_s[i], ql_s[i][QUO_W-1]};
		assign sub   = {1'b0, trial} - {2'b00, den_s[i]};
		assign ge    = ~sub[DEN_W+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
				ql_s[i+1]   <= {ql_s[i][QUO_W-2:0], ge};
				den_s[i+1]  <= den_s[i];
				comp_s[i+1] <= comp_s[i];
				neg_s[i+1]  <= neg_s[i];
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	assign quo  = neg_s[QUO_W] ? -$signed({1'b0, ql_s[QUO_W]}) : $signed({1'b0, ql_s[QUO_W]});
	assign diff = (COMP_W+3)'(comp_s[QUO_W]) - (COMP_W+3)'(quo);

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[QUO_W]) begin
				res <= '0;
			end else if (diff > SAT_HI) begin
				res <= SAT_HI[COMP_W-1:0];
			end else if (diff < SAT_LO) begin
				res <= SAT_LO[COMP_W-1:0];
			end else begin
				res <= diff[COMP_W-1:0];
			end
		end
	end

endmodule

>>> rtl/spectral_leray_projection.sv
// Top level of the spectral Leray projection block: configuration registers,
// wavenumber and dot-product stages and six projection lanes. Uses slp_pkg, slp_div.
module spectral_leray_projection #(
	parameter int MAX_GRID = slp_pkg::MAX_GRID_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [slp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  slp_pkg::coef_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output slp_pkg::proj_t                    out_data
);
	// The block accepts one Fourier coefficient per clock cycle while its output
	// is not stalled, and returns its divergence-free projection. Six parallel
	// divider lanes resolve one quotient bit per stage over 33 stages, behind
	// four stages that wrap the indices, form the products, sum the dot product
	// and |k|^2, and scale the dot product by each wavenumber. The whole pipeline
	// advances together; it halts only while a finished transaction waits at the
	// output, so in_stall simply mirrors a stalled output. Configuration is to be
	// written through a plain write port only while the block is idle; the block
	// itself does not enforce this. Mode and grid size are sampled as a transaction
	// enters. A grid size above MAX_GRID is clamped to MAX_GRID for the wrap point.
	// A zero |k|^2 gives all zeros, and in 2D mode the third component is 0.
	import slp_pkg::*;

	localparam int LAT = 4 + QUO_W + 2;
	localparam logic [N_W-1:0] MAX_N = N_W'(MAX_GRID);

	logic                  mode_q;
	logic [GRID_W-1:0]     grid_q;
	logic [LAT-1:0]        vld_q;
	logic                  en;
	logic                  accept;

	logic [N_W-1:0]        n_clamp;
	logic [N_W-1:0]        half;
	logic [N_W-1:0]        row_w, col_w;
	logic signed [K_W-1:0] k0_c, k1_c, k2_c;

	logic signed [K_W-1:0]    k_s1   [3];
	logic signed [COMP_W-1:0] ure_s1 [3];
	logic signed [COMP_W-1:0] uim_s1 [3];
	logic                     mode_s1;

	logic signed [K_W-1:0]    k_s2   [3];
	logic signed [COMP_W-1:0] ure_s2 [3];
	logic signed [COMP_W-1:0] uim_s2 [3];
	logic signed [PROD_W-1:0] pre_s2 [3];
	logic signed [PROD_W-1:0] pim_s2 [3];
	logic [SQ_W-1:0]          sq_s2  [3];
	logic                     mode_s2;

	logic signed [K_W-1:0]    k_s3   [3];
	logic signed [COMP_W-1:0] ure_s3 [3];
	logic signed [COMP_W-1:0] uim_s3 [3];
	logic signed [DOT_W-1:0]  dre_s3;
	logic signed [DOT_W-1:0]  dim_s3;
	logic [DEN_W-1:0]         den_s3;
	logic                     mode_s3;

	logic signed [COMP_W-1:0] ure_s4 [3];
	logic signed [COMP_W-1:0] uim_s4 [3];
	logic signed [NUM_W-1:0]  nre_s4 [3];
	logic signed [NUM_W-1:0]  nim_s4 [3];
	logic [DEN_W-1:0]         den_s4;
	logic                     zero_s4;
	logic                     mode_s4;

	logic signed [COMP_W-1:0] rre [3];
	logic signed [COMP_W-1:0] rim [3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			grid_q <= GRID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_GRID: grid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves as one unless the oldest transaction is held at the output.
	assign en        = ~(vld_q[LAT-1] & out_stall);
	assign in_stall  = vld_q[LAT-1] & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// Stage 1: indices become signed wavenumbers. Row indices, and column indices in 3D mode, at or above n/2+1 wrap.
	assign n_clamp = ({2'b00, grid_q} > MAX_N) ? MAX_N : {2'b00, grid_q};
	assign half    = (n_clamp >> 1) + N_W'(1);
	assign row_w   = N_W'(in_data.row_index);
	assign col_w   = N_W'(in_data.col_index);

	always_comb begin
		k0_c = (row_w >= half) ? K_W'(row_w - n_clamp) : K_W'(row_w);
		if (mode_q) begin
			k1_c = (col_w >= half) ? K_W'(col_w - n_clamp) : K_W'(col_w);
			k2_c = K_W'(in_data.depth_index);
		end else begin
			k1_c = K_W'(col_w);
			k2_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1[0]   <= k0_c;
			k_s1[1]   <= k1_c;
			k_s1[2]   <= k2_c;
			ure_s1[0] <= in_data.comp1_re;
			uim_s1[0] <= in_data.comp1_im;
			ure_s1[1] <= in_data.comp2_re;
			uim_s1[1] <= in_data.comp2_im;
			ure_s1[2] <= in_data.comp3_re;
			uim_s1[2] <= in_data.comp3_im;
			mode_s1   <= mode_q;
		end
	end

	// Stage 2: per-component products and squared wavenumbers.
	for (genvar c = 0; c < 3; c++) begin : g_s2
		logic signed [2*K_W-1:0] sq_full;
		assign sq_full = (2*K_W)'(k_s1[c]) * (2*K_W)'(k_s1[c]);

		always_ff @(posedge clk) begin
			if (en) begin
				k_s2[c]   <= k_s1[c];
				ure_s2[c] <= ure_s1[c];
				uim_s2[c] <= uim_s1[c];
				pre_s2[c] <= PROD_W'(k_s1[c]) * PROD_W'(ure_s1[c]);
				pim_s2[c] <= PROD_W'(k_s1[c]) * PROD_W'(uim_s1[c]);
				sq_s2[c]  <= sq_full[SQ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: dot products for both parts and |k|^2.
	always_ff @(posedge clk) begin
		if (en) begin
			k_s3    <= k_s2;
			ure_s3  <= ure_s2;
			uim_s3  <= uim_s2;
			dre_s3  <= DOT_W'(pre_s2[0]) + DOT_W'(pre_s2[1]) + DOT_W'(pre_s2[2]);
			dim_s3  <= DOT_W'(pim_s2[0]) + DOT_W'(pim_s2[1]) + DOT_W'(pim_s2[2]);
			den_s3  <= DEN_W'(sq_s2[0]) + DEN_W'(sq_s2[1]) + DEN_W'(sq_s2[2]);
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4: each wavenumber scales the dot product to form the dividends.
	for (genvar c = 0; c < 3; c++) begin : g_s4
		always_ff @(posedge clk) begin
			if (en) begin
				ure_s4[c] <= ure_s3[c];
				uim_s4[c] <= uim_s3[c];
				nre_s4[c] <= NUM_W'(k_s3[c]) * NUM_W'(dre_s3);
				nim_s4[c] <= NUM_W'(k_s3[c]) * NUM_W'(dim_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4  <= den_s3;
			zero_s4 <= (den_s3 == '0);
			mode_s4 <= mode_s3;
		end
	end

	// Six lanes: real and imaginary parts of each component.
	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic fz;
		if (c == 2) begin : g_third
			assign fz = zero_s4 | ~mode_s4;
		end else begin : g_plain
			assign fz = zero_s4;
		end

		slp_div u_div_re (
			.clk        (clk),
			.en         (en),
			.num        (nre_s4[c]),
			.den        (den_s4),
			.comp       (ure_s4[c]),
			.force_zero (fz),
			.res        (rre[c])
		);

		slp_div u_div_im (
			.clk        (clk),
			.en         (en),
			.num        (nim_s4[c]),
			.den        (den_s4),
			.comp       (uim_s4[c]),
			.force_zero (fz),
			.res        (rim[c])
		);
	end

	assign out_data.proj1_re = rre[0];
	assign out_data.proj1_im = rim[0];
	assign out_data.proj2_re = rre[1];
	assign out_data.proj2_im = rim[1];
	assign out_data.proj3_re = rre[2];
	assign out_data.proj3_im = rim[2];

endmodule

>>> rtl/slp_chk.sv
// Port-level checker for the spectral Leray projection block, with the bind
// that attaches it to the top level. Uses slp_pkg for the payload type.
module slp_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           out_valid,
	input  logic           out_stall,
	input  slp_pkg::proj_t out_data
);
	import slp_pkg::*;

	// The input side is only held back by a result that is itself waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// A result disappears only through a completed transaction.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind spectral_leray_projection slp_chk u_slp_chk (.*);
